// ===== design/difference_norm_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// difference_norm_accumulator assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENCE_NORM_ACCUMULATOR_ASSERT_SVH
`define DIFFERENCE_NORM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define DNA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DNA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dna_pkg.sv =====
// ----------------------------------------------------------------------------
// dna_pkg
// Shared types and constants of the difference norm accumulator.
// ----------------------------------------------------------------------------
package dna_pkg;

  // input transfer payload
  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last_element;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [47:0] relative_norm;
    logic [47:0] absolute_norm;
  } out_item_t;

  // norm selector codes; the unused code acts as the maximum norm
  localparam logic [1:0] KIND_MAX    = 2'd0;
  localparam logic [1:0] KIND_SUM    = 2'd1;
  localparam logic [1:0] KIND_EUCLID = 2'd2;

  // register map
  localparam int unsigned CFG_AW        = 3;
  localparam logic        REG_NORM_KIND = 1'b0;

  // saturation limits
  localparam logic [31:0] REL_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0] OUT_MAX = 64'h0000_FFFF_FFFF_FFFF;

  // shared trial subtractor width and step counts
  localparam int unsigned SUB_W      = 36;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned SQRT_STEPS = 32;

endpackage

// ===== design/dna_trial_sub.sv =====
// ----------------------------------------------------------------------------
// dna_trial_sub
// Shared compare-and-subtract unit for divide and square-root steps.
// ----------------------------------------------------------------------------
module dna_trial_sub (
  input  logic [dna_pkg::SUB_W-1:0] a,
  input  logic [dna_pkg::SUB_W-1:0] b,
  output logic                      ge,
  output logic [dna_pkg::SUB_W-1:0] diff
);

  logic [dna_pkg::SUB_W:0] full;

  // borrow out tells whether a >= b
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[dna_pkg::SUB_W-1:0];
  assign ge   = ~full[dna_pkg::SUB_W];

endmodule

// ===== design/dna_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dna_cfg_regs
// APB-style register file holding the norm selector.
// ----------------------------------------------------------------------------
module dna_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dna_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [1:0]                 norm_kind
);

  logic [1:0] norm_kind_r;
  logic [1:0] norm_kind_nxt;
  logic       hit;

  // word index decode
  assign hit = (paddr[dna_pkg::CFG_AW-1] == dna_pkg::REG_NORM_KIND);

  // write on the access phase
  always_comb begin
    norm_kind_nxt = norm_kind_r;
    if (psel && penable && pwrite && hit) begin
      norm_kind_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_kind_r <= dna_pkg::KIND_MAX;
    end else begin
      norm_kind_r <= norm_kind_nxt;
    end
  end

  // read back and handshake
  assign prdata    = hit ? {30'd0, norm_kind_r} : 32'd0;
  assign pready    = 1'b1;
  assign norm_kind = norm_kind_r;

endmodule

// ===== design/difference_norm_accumulator.sv =====
// ----------------------------------------------------------------------------
// difference_norm_accumulator
// Streams signed fixed-point pairs and emits relative and absolute norms.
// ----------------------------------------------------------------------------
// One pair is taken at a time; in_stall stays high until it is folded into
// the accumulators. A pair whose ratio needs a real division passes through
// the transfer, 31 restoring-divide steps on the shared trial subtractor and
// three accumulate states around the single 32x32 multiplier; a pair where a
// value is zero or the ratio saturates skips the divide. The last pair of a
// vector adds a posting state, plus 64 square-root steps on the same
// subtractor in Euclidean mode; posting waits while a previous result is
// still stalled. norm_kind sits at byte address 0 of the APB port (0 max,
// 1 sum, 2 Euclidean, 3 acts as max) and is sampled with each pair.
// ----------------------------------------------------------------------------
module difference_norm_accumulator #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dna_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dna_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dna_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned DW      = 32 + FRACTION_BITS;
  localparam int unsigned TOP_W   = DW - dna_pkg::DIV_STEPS;
  localparam logic [31:0] REL_ONE = 32'd1 << FRACTION_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ACC_SQ, S_ACC_REL, S_ACC_ABS, S_SQRT_REL, S_SQRT_ABS, S_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [33:0]        rem_r, rem_nxt;
  logic [63:0]        sh_r, sh_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [31:0]        ax_r, ax_nxt;
  logic [31:0]        rel_d_r, rel_d_nxt;
  logic [31:0]        abs_d_r, abs_d_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic               last_r, last_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [63:0]        rel_acc_r, rel_acc_nxt;
  logic [63:0]        abs_acc_r, abs_acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  dna_pkg::out_item_t out_data_r, out_data_nxt;

  logic [1:0]                norm_kind;
  logic [dna_pkg::SUB_W-1:0] sub_a, sub_b, sub_diff;
  logic                      sub_ge;
  logic signed [32:0]        diff_in;
  logic [31:0]               absd_in;
  logic [31:0]               ax_in;
  logic [DW-1:0]             dividend;
  logic [TOP_W-1:0]          div_top;
  logic [31:0]               mul_op;
  logic [63:0]               mul_out;

  // saturating sum, sum of squares or running maximum
  function automatic logic [63:0] accum(input logic [63:0] acc, input logic [31:0] d,
                                        input logic [63:0] sq, input logic [1:0] kind);
    logic [63:0] addend;
    logic [64:0] s;
    logic [63:0] res;
    addend = (kind == dna_pkg::KIND_EUCLID) ? sq : {32'd0, d};
    s      = {1'b0, acc} + {1'b0, addend};
    case (kind)
      dna_pkg::KIND_SUM, dna_pkg::KIND_EUCLID: begin
        res = s[64] ? {64{1'b1}} : s[63:0];
      end
      default: begin
        res = ({32'd0, d} > acc) ? {32'd0, d} : acc;
      end
    endcase
    return res;
  endfunction

  // output clamp to 48 bits
  function automatic logic [47:0] clamp_out(input logic [63:0] v);
    logic [63:0] c;
    c = (v > dna_pkg::OUT_MAX) ? dna_pkg::OUT_MAX : v;
    return c[47:0];
  endfunction

  dna_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .norm_kind (norm_kind)
  );

  // incoming pair: differences and divider setup
  assign diff_in  = 33'(in_data.x_value) - 33'(in_data.y_value);
  assign absd_in  = diff_in[32] ? 32'(-diff_in) : diff_in[31:0];
  assign ax_in    = in_data.x_value[31] ? (~in_data.x_value + 32'd1) : in_data.x_value;
  assign dividend = {absd_in, {FRACTION_BITS{1'b0}}};
  assign div_top  = dividend[DW-1:dna_pkg::DIV_STEPS];

  // shared trial subtractor operand select
  always_comb begin
    case (state_r)
      S_DIV: begin
        sub_a = {3'd0, rem_r[31:0], sh_r[63]};
        sub_b = {4'd0, ax_r};
      end
      S_SQRT_REL, S_SQRT_ABS: begin
        sub_a = {rem_r, sh_r[63:62]};
        sub_b = {2'd0, q_r, 2'b01};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  dna_trial_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  // single squaring multiplier
  assign mul_op  = (state_r == S_ACC_SQ) ? rel_d_r : abs_d_r;
  assign mul_out = {32'd0, mul_op} * {32'd0, mul_op};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    q_nxt         = q_r;
    ax_nxt        = ax_r;
    rel_d_nxt     = rel_d_r;
    abs_d_nxt     = abs_d_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    rel_acc_nxt   = rel_acc_r;
    abs_acc_nxt   = abs_acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          abs_d_nxt = absd_in;
          ax_nxt    = ax_in;
          kind_nxt  = norm_kind;
          last_nxt  = in_data.last_element;
          state_nxt = S_ACC_SQ;
          if (in_data.x_value == 32'sd0 && in_data.y_value == 32'sd0) begin
            rel_d_nxt = 32'd0;
          end else if (in_data.x_value == 32'sd0 || in_data.y_value == 32'sd0) begin
            rel_d_nxt = REL_ONE;
          end else if (32'(div_top) >= ax_in) begin
            rel_d_nxt = dna_pkg::REL_MAX;
          end else begin
            rem_nxt   = 34'(div_top);
            sh_nxt    = {dividend[dna_pkg::DIV_STEPS-1:0], 33'd0};
            q_nxt     = 32'd0;
            cnt_nxt   = 5'(dna_pkg::DIV_STEPS - 1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = sub_ge ? {2'd0, sub_diff[31:0]} : {2'd0, sub_a[31:0]};
        sh_nxt  = {sh_r[62:0], 1'b0};
        q_nxt   = {q_r[30:0], sub_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          rel_d_nxt = {q_r[30:0], sub_ge};
          state_nxt = S_ACC_SQ;
        end
      end
      S_ACC_SQ: begin
        prod_nxt  = mul_out;
        state_nxt = S_ACC_REL;
      end
      S_ACC_REL: begin
        rel_acc_nxt = accum(rel_acc_r, rel_d_r, prod_r, kind_r);
        prod_nxt    = mul_out;
        state_nxt   = S_ACC_ABS;
      end
      S_ACC_ABS: begin
        abs_acc_nxt = accum(abs_acc_r, abs_d_r, prod_r, kind_r);
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (kind_r == dna_pkg::KIND_EUCLID) begin
          // rel_acc_r is final here
          sh_nxt    = rel_acc_r;
          rem_nxt   = 34'd0;
          q_nxt     = 32'd0;
          cnt_nxt   = 5'(dna_pkg::SQRT_STEPS - 1);
          state_nxt = S_SQRT_REL;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SQRT_REL: begin
        rem_nxt = sub_ge ? sub_diff[33:0] : sub_a[33:0];
        sh_nxt  = {sh_r[61:0], 2'b00};
        q_nxt   = {q_r[30:0], sub_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          rel_acc_nxt = {32'd0, q_r[30:0], sub_ge};
          sh_nxt      = abs_acc_r;
          rem_nxt     = 34'd0;
          q_nxt       = 32'd0;
          cnt_nxt     = 5'(dna_pkg::SQRT_STEPS - 1);
          state_nxt   = S_SQRT_ABS;
        end
      end
      S_SQRT_ABS: begin
        rem_nxt = sub_ge ? sub_diff[33:0] : sub_a[33:0];
        sh_nxt  = {sh_r[61:0], 2'b00};
        q_nxt   = {q_r[30:0], sub_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          abs_acc_nxt = {32'd0, q_r[30:0], sub_ge};
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        // post once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.relative_norm = clamp_out(rel_acc_r);
          out_data_nxt.absolute_norm = clamp_out(abs_acc_r);
          out_valid_nxt              = 1'b1;
          rel_acc_nxt                = 64'd0;
          abs_acc_nxt                = 64'd0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rel_acc_r   <= 64'd0;
      abs_acc_r   <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rel_acc_r   <= rel_acc_nxt;
      abs_acc_r   <= abs_acc_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    sh_r    <= sh_nxt;
    q_r     <= q_nxt;
    ax_r    <= ax_nxt;
    rel_d_r <= rel_d_nxt;
    abs_d_r <= abs_d_nxt;
    kind_r  <= kind_nxt;
    last_r  <= last_nxt;
    prod_r  <= prod_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/dna_port_checker.sv =====
// ----------------------------------------------------------------------------
// dna_port_checker
// Port-level checks of the difference norm accumulator, bound to the top.
// ----------------------------------------------------------------------------
`include "difference_norm_accumulator_assert.svh"

module dna_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dna_pkg::out_item_t out_data
);

  // one pair at a time: the input closes right after a transfer
  `DNA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "input open after transfer")

  // a new result only comes out of a pair in progress
  `DNA_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result without pending pair")

  // a stalled result holds
  `DNA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind difference_norm_accumulator dna_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
